>>> src/trsb_pkg.sv
// ----------------------------------------------------------------------------
// trsb_pkg
// Shared types and constants for the trail ribbon strip builder.
// ----------------------------------------------------------------------------
package trsb_pkg;

  // Default ring size
  localparam int POINT_COUNT_DEF = 16;

  // Field widths
  localparam int POS_W   = 32;
  localparam int LIFE_W  = 16;
  localparam int ALPHA_W = 8;
  localparam int KIND_W  = 2;

  // Shared divider geometry
  localparam int DIVN_W  = 24;   // dividend / quotient shift register
  localparam int DIVD_W  = 16;   // divisor and remainder
  localparam int STEP_W  = 5;

  // Reset value of the lifetime register
  localparam logic [LIFE_W-1:0] MAX_LIFE_RST = 16'd1000;

  // Tenth scale: (d * 6554) >> 16
  localparam logic signed [13:0] TENTH_SCALE = 14'sd6554;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Vertex kinds
  localparam logic [KIND_W-1:0] KIND_HEAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd2;

  // Divider request
  typedef struct packed {
    logic              go;
    logic [DIVD_W-1:0] rem_init;
    logic [DIVN_W-1:0] num_init;
    logic [DIVD_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_QDIV,
    ST_QWAIT,
    ST_FILL,
    ST_ARD,
    ST_AWR,
    ST_HRD,
    ST_HLD,
    ST_HDIV,
    ST_HWAIT,
    ST_HOUT,
    ST_WRD,
    ST_WLD,
    ST_NRD,
    ST_NLD,
    ST_MX,
    ST_MY,
    ST_WDIV,
    ST_WWAIT,
    ST_OUTL,
    ST_OUTR
  } state_t;

endpackage

>>> src/trsb_div.sv
// ----------------------------------------------------------------------------
// trsb_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module trsb_div import trsb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              busy,
  output logic [DIVN_W-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIVN_W-1:0] num_r, num_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] dvs_r, dvs_nxt;
  logic [DIVD_W:0]   trial;
  logic              ge;

  // One compare-subtract step
  always_comb begin
    trial    = {rem_r, num_r[DIVN_W-1]};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      num_nxt  = req.num_init;
      rem_nxt  = req.rem_init;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[DIVN_W-2:0], ge};
      rem_nxt = ge ? DIVD_W'(trial - {1'b0, dvs_r}) : trial[DIVD_W-1:0];
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

>>> src/trail_ribbon_strip_builder_core.sv
// ----------------------------------------------------------------------------
// trail_ribbon_strip_builder_core
// Ring of trail points aged on each tick and emitted as a triangle strip.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per valid/ready handshake. operation start loads the
//           ring at the parent; operation tick ages the ring and emits
//           1 + 2*POINT_COUNT vertices on out_*.
//   out_* : one vertex per handshake, from an output register; the last
//           vertex of a strip carries out_last_vertex and out_all_asleep.
//   cfg_* : writes max_lifetime; cfg_ready is always high. Write only while
//           the block is idle.
// Sequence (N = POINT_COUNT):
//   start: a reciprocal multiply step and a remainder step, then a fill
//          of all N points.
//   tick : an aging pass over all N points, the head vertex, a load of
//          the first point, then one pass per point pair that waits on
//          the shared divider for alpha.
//   One request at a time: in_ready is high only while idle. The single
//   point memory port and the shared divider serialise this work.
// Reset: the ring reads as zero, max_lifetime returns to 1000.
// A stalled receiver holds the sequencer on the waiting vertex.
// ----------------------------------------------------------------------------
module trail_ribbon_strip_builder_core import trsb_pkg::*; #(
  parameter int POINT_COUNT = POINT_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [LIFE_W-1:0]         cfg_max_lifetime,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic [LIFE_W-1:0]         in_elapsed,
  input  logic                      in_parent_valid,
  input  logic signed [POS_W-1:0]   in_parent_x,
  input  logic signed [POS_W-1:0]   in_parent_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [POS_W-1:0]   out_vertex_x,
  output logic signed [POS_W-1:0]   out_vertex_y,
  output logic [ALPHA_W-1:0]        out_alpha,
  output logic [KIND_W-1:0]         out_vertex_kind,
  output logic                      out_all_asleep,
  output logic                      out_last_vertex
);

  localparam int IDX_W = $clog2(POINT_COUNT);
  localparam int CNT_W = $clog2(POINT_COUNT + 1);
  localparam int RW    = IDX_W + 1;
  localparam int ENT_W = 2 * POS_W + LIFE_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINT_COUNT - 1);

  // max/N by reciprocal multiply, exact for every 16-bit max
  localparam int RECIP_SH = LIFE_W + IDX_W;
  localparam int RP_W     = RECIP_SH + LIFE_W;
  localparam logic [LIFE_W+1:0] RECIP =
    (LIFE_W+2)'(((64'd1 << RECIP_SH) + 64'(POINT_COUNT) - 64'd1) / 64'(POINT_COUNT));

  state_t state_r, state_nxt;

  // Request capture
  logic                op_r, pv_r;
  logic [LIFE_W-1:0]   dt_r, max_r;
  logic [POS_W-1:0]    px_r, py_r;

  // Ring bookkeeping
  logic [IDX_W-1:0]    idx_r, nb_idx_r, step_r, oldest_r;
  logic [CNT_W-1:0]    acnt_r;
  logic [POINT_COUNT-1:0] asleep_r, vld_r;

  // Start fill accumulator: floor(i*max/N) built incrementally
  logic [LIFE_W-1:0]   q_r, qm_r;
  logic [RW-1:0]       r_r, rm_r, r_sum;
  logic [RP_W-1:0]     recip_prod;
  logic [LIFE_W-1:0]   qn_rem;

  // Point memory
  logic [ENT_W-1:0]    mem [POINT_COUNT];
  logic [ENT_W-1:0]    rd_data_r, wr_data;
  logic                rd_vld_r, rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [POS_W-1:0]    rd_x, rd_y;
  logic [LIFE_W-1:0]   rd_life;

  // Walk working set
  logic [POS_W-1:0]    cur_x_r, cur_y_r, nb_x_r, nb_y_r, ox_r, oy_r;
  logic [LIFE_W-1:0]   cur_life_r, nb_life_r;

  // Output register
  logic                out_valid_r, out_asleep_r, out_last_r;
  logic [POS_W-1:0]    out_x_r, out_y_r;
  logic [ALPHA_W-1:0]  out_alpha_r;
  logic [KIND_W-1:0]   out_kind_r;

  // Shared units
  div_req_t            div_req;
  logic                div_busy;
  logic [DIVN_W-1:0]   div_quot;
  logic signed [POS_W-1:0] mul_in;
  logic signed [POS_W+13:0] mul_prod;
  logic [POS_W-1:0]    scaled;
  logic [DIVN_W-1:0]   life255;
  logic [ALPHA_W-1:0]  alpha_val;

  // Index helpers
  logic [IDX_W-1:0]    idx_inc, idx_dec, nb_sel, oldest_inc;

  // Aging of one point
  logic [LIFE_W-1:0]   life_dec;
  logic                expire;

  logic in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid_r && out_ready;

  assign idx_inc    = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
  assign idx_dec    = (idx_r == '0) ? IDX_LAST : idx_r - IDX_W'(1);
  assign nb_sel     = (idx_inc == oldest_r) ? idx_dec : idx_inc;
  assign oldest_inc = (oldest_r == IDX_LAST) ? '0 : oldest_r + IDX_W'(1);

  // Entries never written read as zero
  assign rd_x    = rd_vld_r ? rd_data_r[ENT_W-1 -: POS_W] : '0;
  assign rd_y    = rd_vld_r ? rd_data_r[LIFE_W +: POS_W] : '0;
  assign rd_life = rd_vld_r ? rd_data_r[LIFE_W-1:0] : '0;

  assign life_dec = (rd_life > dt_r) ? rd_life - dt_r : '0;
  assign expire   = !asleep_r[idx_r] && (life_dec == '0);

  assign r_sum = r_r + rm_r;

  // Quotient and remainder of max by the ring size
  assign recip_prod = RP_W'(max_r) * RP_W'(RECIP);
  assign qn_rem     = max_r - LIFE_W'(qm_r * LIFE_W'(POINT_COUNT));

  // Tenth of the perpendicular, floor via arithmetic shift
  assign mul_in   = (state_r == ST_MX) ? $signed(nb_y_r - cur_y_r)
                                       : $signed(cur_x_r - nb_x_r);
  assign mul_prod = mul_in * TENTH_SCALE;
  assign scaled   = {{2{mul_prod[POS_W+13]}}, mul_prod[POS_W+13:16]};

  // 255 * life by shift and subtract
  assign life255 = {cur_life_r, 8'd0} - DIVN_W'(cur_life_r);

  always_comb begin
    if (max_r == '0)             alpha_val = '0;
    else if (cur_life_r >= max_r) alpha_val = '1;
    else                         alpha_val = div_quot[ALPHA_W-1:0];
  end

  trsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = (in_operation == OP_START) ? ST_QDIV : ST_ARD;
      ST_QDIV:  state_nxt = ST_QWAIT;
      ST_QWAIT: state_nxt = ST_FILL;
      ST_FILL:  if (idx_r == IDX_LAST) state_nxt = ST_IDLE;
      ST_ARD:   state_nxt = ST_AWR;
      ST_AWR:   state_nxt = (idx_r == IDX_LAST) ? ST_HRD : ST_ARD;
      ST_HRD:   state_nxt = ST_HLD;
      ST_HLD:   state_nxt = ST_HDIV;
      ST_HDIV:  state_nxt = ST_HWAIT;
      ST_HWAIT: if (!div_busy) state_nxt = ST_HOUT;
      ST_HOUT:  if (out_acc) state_nxt = ST_WRD;
      ST_WRD:   state_nxt = ST_WLD;
      ST_WLD:   state_nxt = ST_NRD;
      ST_NRD:   state_nxt = ST_NLD;
      ST_NLD:   state_nxt = ST_MX;
      ST_MX:    state_nxt = ST_MY;
      ST_MY:    state_nxt = ST_WDIV;
      ST_WDIV:  state_nxt = ST_WWAIT;
      ST_WWAIT: if (!div_busy) state_nxt = ST_OUTL;
      ST_OUTL:  if (out_acc) state_nxt = ST_OUTR;
      ST_OUTR:  if (out_acc) state_nxt = (step_r == IDX_LAST) ? ST_IDLE : ST_NRD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: memory port and divider requests
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = idx_r;
    wr_en    = 1'b0;
    wr_data  = {px_r, py_r, q_r};
    div_req  = '0;
    case (state_r)
      ST_FILL: wr_en = 1'b1;
      ST_ARD, ST_WRD: rd_en = 1'b1;
      ST_AWR: begin
        wr_en = 1'b1;
        if (expire && pv_r) wr_data = {px_r, py_r, max_r};
        else                wr_data = {rd_x, rd_y, life_dec};
      end
      ST_HRD: begin
        rd_en   = 1'b1;
        rd_addr = oldest_r;
      end
      ST_NRD: begin
        rd_en   = 1'b1;
        rd_addr = nb_sel;
      end
      ST_HDIV, ST_WDIV: begin
        div_req.go       = 1'b1;
        div_req.rem_init = life255[DIVN_W-1:8];
        div_req.num_init = {life255[7:0], 16'd0};
        div_req.divisor  = max_r;
        div_req.steps    = STEP_W'(8);
      end
      default: ;
    endcase
  end

  // Point memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[idx_r] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_r       <= MAX_LIFE_RST;
      oldest_r    <= '0;
      acnt_r      <= '0;
      asleep_r    <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) max_r <= cfg_max_lifetime;
      case (state_r)
        ST_FILL: begin
          vld_r[idx_r]    <= 1'b1;
          asleep_r[idx_r] <= 1'b0;
          oldest_r        <= '0;
          acnt_r          <= '0;
        end
        ST_AWR: begin
          vld_r[idx_r] <= 1'b1;
          if (expire) begin
            oldest_r <= oldest_inc;
            if (!pv_r) begin
              asleep_r[idx_r] <= 1'b1;
              acnt_r          <= acnt_r + CNT_W'(1);
            end
          end
        end
        ST_HWAIT, ST_WWAIT: if (!div_busy) out_valid_r <= 1'b1;
        ST_HOUT: if (out_acc) out_valid_r <= 1'b0;
        ST_OUTR: if (out_acc) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        op_r  <= in_operation;
        dt_r  <= in_elapsed;
        pv_r  <= in_parent_valid;
        px_r  <= in_parent_x;
        py_r  <= in_parent_y;
        idx_r <= '0;
      end
      ST_QDIV: qm_r <= recip_prod[RECIP_SH +: LIFE_W];
      ST_QWAIT: begin
        rm_r <= RW'(qn_rem[IDX_W-1:0]);
        q_r  <= '0;
        r_r  <= '0;
      end
      ST_FILL: begin
        idx_r <= idx_inc;
        if (r_sum >= RW'(POINT_COUNT)) begin
          r_r <= r_sum - RW'(POINT_COUNT);
          q_r <= q_r + qm_r + LIFE_W'(1);
        end else begin
          r_r <= r_sum;
          q_r <= q_r + qm_r;
        end
      end
      ST_AWR: idx_r <= idx_inc;
      ST_HLD, ST_WLD: begin
        cur_x_r    <= rd_x;
        cur_y_r    <= rd_y;
        cur_life_r <= rd_life;
      end
      ST_HWAIT: begin
        out_x_r      <= cur_x_r;
        out_y_r      <= cur_y_r;
        out_alpha_r  <= alpha_val;
        out_kind_r   <= KIND_HEAD;
        out_asleep_r <= 1'b0;
        out_last_r   <= 1'b0;
      end
      ST_HOUT: begin
        idx_r  <= oldest_inc;
        step_r <= '0;
      end
      ST_NRD: nb_idx_r <= nb_sel;
      ST_NLD: begin
        nb_x_r    <= rd_x;
        nb_y_r    <= rd_y;
        nb_life_r <= rd_life;
      end
      ST_MX: ox_r <= scaled;
      ST_MY: oy_r <= scaled;
      ST_WWAIT: begin
        out_x_r      <= cur_x_r + ox_r;
        out_y_r      <= cur_y_r + oy_r;
        out_alpha_r  <= alpha_val;
        out_kind_r   <= KIND_LEFT;
        out_asleep_r <= 1'b0;
        out_last_r   <= 1'b0;
      end
      ST_OUTL: if (out_acc) begin
        out_x_r    <= cur_x_r - ox_r;
        out_y_r    <= cur_y_r - oy_r;
        out_kind_r <= KIND_RIGHT;
        if (step_r == IDX_LAST) begin
          out_last_r   <= 1'b1;
          out_asleep_r <= (acnt_r == CNT_W'(POINT_COUNT)) && (op_r == OP_TICK);
        end
      end
      ST_OUTR: if (out_acc) begin
        cur_x_r    <= nb_x_r;
        cur_y_r    <= nb_y_r;
        cur_life_r <= nb_life_r;
        idx_r      <= nb_idx_r;
        step_r     <= step_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_vertex_x    = out_x_r;
  assign out_vertex_y    = out_y_r;
  assign out_alpha       = out_alpha_r;
  assign out_vertex_kind = out_kind_r;
  assign out_all_asleep  = out_asleep_r;
  assign out_last_vertex = out_last_r;

  // Checks
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("vertex pending while idle");

  a_sleep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r <= CNT_W'(POINT_COUNT)) else $error("sleep count beyond ring size");

  a_oldest_range: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r <= IDX_LAST) else $error("oldest index out of ring");

  a_last_is_right: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_vertex) |-> (out_vertex_kind == KIND_RIGHT))
    else $error("strip ends on a non-right vertex");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy) else $error("divider busy while idle");

endmodule
